@@ hw/rtl/kss_pkg.sv @@
`default_nettype none
package kss_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_LOOKUP   = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_WALK_OLD = 3'd4,
    CMD_WALK_NEW = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic        replace;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] entry_key;
    logic [4:0]  entries;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_HOME,
    ST_FIND_GRP,
    ST_UNLINK,
    ST_DROP,
    ST_PROBE,
    ST_LINK,
    ST_APPEND,
    ST_CLEAR,
    ST_WALK,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find_start;
    logic find_step;
    logic unlink;
    logic drop_step;
    logic probe_start;
    logic probe_step;
    logic link;
    logic append_step;
    logic clear_all;
    logic walk_start;
    logic walk_step;
    logic res_load;
    logic res_walk;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic home_hit;
    logic grp_hit;
    logic grp_end;
    logic drop_done;
    logic probe_free;
    logic probe_end;
    logic full;
    logic append_done;
    logic need_group;
    logic empty;
    logic walk_last;
    logic found;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/kss_datapath.sv @@
`default_nettype none
module kss_datapath #(
  parameter int CAPACITY = kss_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kss_pkg::KEY_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  kss_pkg::in_word_t in_word,
  input  kss_pkg::ctl_t    ctl,
  output kss_pkg::sts_t    sts,
  output kss_pkg::out_word_t res
);
  import kss_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [SW:0] NONE = (SW+1)'(CAPACITY);
  localparam logic [SW-1:0] TOP = SW'(CAPACITY - 1);

  logic [CAPACITY-1:0] live_r;
  logic [KEY_BITS-1:0] slot_key_r [CAPACITY];
  logic [SW-1:0] prev_r [CAPACITY];
  logic [SW-1:0] next_r [CAPACITY];
  logic [SW:0]   head_r [CAPACITY];
  logic [SW:0]   link_r [CAPACITY];
  logic [SW-1:0] oldest_r, newest_r;
  logic [CW-1:0] count_r;

  logic [KEY_BITS-1:0] key_r;
  logic [31:0]         echo_r;
  logic [SW-1:0]       home_r;
  logic [SW:0]         cur_r;     // group walker / found slot
  logic [SW:0]         prv_r;
  logic [SW-1:0]       pos_r;     // probe / walk / target slot
  logic [CW-1:0]       cnt_r;
  logic                hit_r;
  out_word_t           res_r;

  logic [SW-1:0] cs, tgt_home, nxt_pos;
  assign cs = cur_r[SW-1:0];
  assign nxt_pos = (pos_r == TOP) ? '0 : pos_r + 1'b1;

  function automatic logic [SW-1:0] home_of(input logic [KEY_BITS-1:0] k);
    return SW'(k % CAPACITY);
  endfunction

  assign tgt_home = home_of(slot_key_r[cs]);

  assign sts.home_hit    = live_r[home_r] && slot_key_r[home_r] == key_r;
  assign sts.grp_hit     = !cur_r[SW] && live_r[cs] && slot_key_r[cs] == key_r;
  assign sts.grp_end     = cur_r[SW] || cnt_r == CW'(CAPACITY);
  assign sts.drop_done   = cur_r[SW] || cnt_r == CW'(CAPACITY) || cur_r == {1'b0, pos_r};
  assign sts.probe_free  = !live_r[pos_r];
  assign sts.probe_end   = cnt_r == CW'(CAPACITY - 1);
  assign sts.full        = count_r == CW'(CAPACITY);
  assign sts.append_done = cur_r[SW] || link_r[cs] >= NONE || cnt_r == CW'(CAPACITY);
  assign sts.need_group  = pos_r != home_r;
  assign sts.empty       = count_r == '0;
  assign sts.walk_last   = cnt_r == count_r - 1'b1;
  assign sts.found       = hit_r;

  // unlink of slot cs, shared by remove, replace and clear
  logic [SW-1:0] up, un;
  assign up = prev_r[cs];
  assign un = next_r[cs];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      oldest_r <= '0;
      newest_r <= '0;
      count_r  <= '0;
      for (int i = 0; i < CAPACITY; i++) head_r[i] <= NONE;
    end else begin
      if (ctl.load) begin
        key_r  <= KEY_BITS'(in_word.key);
        echo_r <= in_word.key;
        home_r <= home_of(KEY_BITS'(in_word.key));
        hit_r  <= 1'b0;
      end
      if (ctl.find_start) begin
        if (sts.home_hit) begin
          cur_r <= {1'b0, home_r};
          pos_r <= home_r;
          hit_r <= 1'b1;
        end else begin
          cur_r <= head_r[home_r];
          cnt_r <= '0;
        end
      end
      if (ctl.find_step) begin
        if (sts.grp_hit) begin
          hit_r <= 1'b1;
          pos_r <= cs;
        end else begin
          cur_r <= link_r[cs];
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (ctl.unlink) begin
        live_r[cs] <= 1'b0;
        if (count_r == CW'(1)) begin
          oldest_r <= '0;
          newest_r <= '0;
        end else begin
          if (oldest_r == cs) oldest_r <= un;
          if (newest_r == cs) newest_r <= up;
        end
        next_r[up] <= un;
        prev_r[un] <= up;
        count_r <= count_r - 1'b1;
        // set up group drop of cs from its home group
        pos_r <= cs;
        home_r <= tgt_home;
        prv_r <= NONE;
        cnt_r <= '0;
        cur_r <= head_r[tgt_home];
      end
      if (ctl.drop_step) begin
        if (cur_r == {1'b0, pos_r}) begin
          if (prv_r[SW]) head_r[home_r] <= link_r[cs];
          else link_r[prv_r[SW-1:0]] <= link_r[cs];
        end else if (!sts.drop_done) begin
          prv_r <= cur_r;
          cur_r <= link_r[cs];
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (ctl.probe_start) begin
        home_r <= home_of(key_r);
        pos_r  <= home_of(key_r);
        cnt_r  <= '0;
      end
      if (ctl.probe_step) begin
        pos_r <= nxt_pos;
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.link) begin
        hit_r <= 1'b1;
        live_r[pos_r] <= 1'b1;
        slot_key_r[pos_r] <= key_r;
        link_r[pos_r] <= NONE;
        if (count_r == '0) begin
          oldest_r <= pos_r;
          newest_r <= pos_r;
          prev_r[pos_r] <= pos_r;
          next_r[pos_r] <= pos_r;
        end else begin
          prev_r[pos_r] <= newest_r;
          next_r[pos_r] <= oldest_r;
          next_r[newest_r] <= pos_r;
          prev_r[oldest_r] <= pos_r;
          newest_r <= pos_r;
        end
        count_r <= count_r + 1'b1;
        cur_r <= head_r[home_r];
        cnt_r <= '0;
        if (pos_r != home_r && head_r[home_r] >= NONE) head_r[home_r] <= {1'b0, pos_r};
      end
      if (ctl.append_step) begin
        if (sts.append_done) begin
          if (!cur_r[SW]) link_r[cs] <= {1'b0, pos_r};
        end else begin
          cur_r <= link_r[cs];
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (ctl.clear_all) begin
        cur_r <= {1'b0, oldest_r};
      end
      if (ctl.walk_start) begin
        pos_r <= (in_word.cmd == CMD_WALK_OLD) ? oldest_r : newest_r;
        cnt_r <= '0;
      end
      if (ctl.walk_step) begin
        pos_r <= (in_word.cmd == CMD_WALK_OLD) ? next_r[pos_r] : prev_r[pos_r];
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.res_load) begin
        res_r.ok        <= hit_r || in_word.cmd == CMD_CLEAR;
        res_r.slot      <= hit_r ? 4'(pos_r) : '0;
        res_r.entry_key <= echo_r;
        res_r.entries   <= 5'(count_r);
        res_r.last      <= 1'b1;
      end
      if (ctl.res_walk) begin
        res_r.ok        <= 1'b1;
        res_r.slot      <= 4'(pos_r);
        res_r.entry_key <= 32'(slot_key_r[pos_r]);
        res_r.entries   <= 5'(count_r);
        res_r.last      <= sts.walk_last;
      end
    end
  end

  // hit_r for results: set from controller paths via found slot kept in pos_r
  assign res = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/kss_ctrl.sv @@
`default_nettype none
module kss_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  kss_pkg::in_word_t in_word,
  output logic              out_valid,
  input  wire               out_stall,
  input  kss_pkg::sts_t     sts,
  output kss_pkg::ctl_t     ctl
);
  import kss_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   walk_r, walk_nxt;
  logic   rem_r, rem_nxt;   // removal is the whole command
  logic   ins_r, ins_nxt;   // insert command; the insert follows any removal
  cmd_t   cmd;
  logic   slot_free;

  assign cmd = cmd_t'(in_word.cmd);
  assign slot_free = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      walk_r  <= 1'b0;
      rem_r   <= 1'b0;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      walk_r  <= walk_nxt;
      rem_r   <= rem_nxt;
      ins_r   <= ins_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    walk_nxt  = walk_r;
    rem_nxt   = rem_r;
    ins_nxt   = ins_r;
    ctl       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = ST_FIND_HOME;
        end
      end
      ST_FIND_HOME: begin
        ins_nxt = 1'b0;
        rem_nxt = 1'b0;
        case (cmd)
          CMD_INSERT: begin
            ins_nxt = 1'b1;
            if (in_word.replace && !sts.empty) begin
              ctl.find_start = 1'b1;
              state_nxt = sts.home_hit ? ST_UNLINK : ST_FIND_GRP;
            end else state_nxt = ST_PROBE;
          end
          CMD_REMOVE, CMD_LOOKUP: begin
            rem_nxt = cmd == CMD_REMOVE;
            if (sts.empty) state_nxt = ST_RESULT;
            else begin
              ctl.find_start = 1'b1;
              state_nxt = sts.home_hit ? (rem_nxt ? ST_UNLINK : ST_RESULT) : ST_FIND_GRP;
            end
          end
          CMD_CLEAR: begin
            ctl.clear_all = 1'b1;
            state_nxt = ST_CLEAR;
          end
          CMD_WALK_OLD, CMD_WALK_NEW: begin
            if (sts.empty) state_nxt = ST_RESULT;
            else begin
              ctl.walk_start = 1'b1;
              state_nxt = ST_WALK;
            end
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_FIND_GRP: begin
        if (sts.grp_hit) begin
          ctl.find_step = 1'b1;
          state_nxt = (rem_r || ins_r) ? ST_UNLINK : ST_RESULT;
        end else if (sts.grp_end) state_nxt = ins_r ? ST_PROBE : ST_RESULT;
        else ctl.find_step = 1'b1;
      end
      ST_UNLINK: begin
        ctl.unlink = 1'b1;
        state_nxt = ST_DROP;
      end
      ST_DROP: begin
        ctl.drop_step = 1'b1;
        if (sts.drop_done) begin
          if (ins_r) state_nxt = ST_PROBE;
          else if (cmd == CMD_CLEAR) begin
            ctl.clear_all = 1'b1;
            state_nxt = ST_CLEAR;
          end else state_nxt = ST_RESULT;
        end
      end
      ST_PROBE: begin
        if (sts.full) state_nxt = ST_RESULT;
        else begin
          ctl.probe_start = 1'b1;
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if (sts.probe_free) begin
          ctl.link = 1'b1;
          state_nxt = sts.need_group ? ST_APPEND : ST_RESULT;
        end else ctl.probe_step = 1'b1;
      end
      ST_APPEND: begin
        ctl.append_step = 1'b1;
        if (sts.append_done) state_nxt = ST_RESULT;
      end
      ST_CLEAR: begin
        if (sts.empty) state_nxt = ST_RESULT;
        else state_nxt = ST_UNLINK;
      end
      ST_WALK: begin
        if (slot_free) begin
          ctl.res_walk = 1'b1;
          ov_nxt = 1'b1;
          if (sts.walk_last) state_nxt = ST_IDLE;
          else ctl.walk_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          ctl.res_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/keyed_slot_store.sv @@
`default_nettype none
// channel  ports                          word
// in       in_valid, in_stall, in_data    in_word_t (cmd, key, replace)
// out      out_valid, out_stall, out_data out_word_t (ok, slot, entry_key, entries, last)
// probe, group search, group drop and group append visit one slot a cycle; an insert with
// replace searches, unlinks, drops, probes and appends, a remove searches, unlinks and
// drops, clear unlinks and drops each entry, a walk one entry a cycle unless stalled
// reset is synchronous; after it the table is empty and ready at once
// an output stall holds the result register and the sequencer behind it
module keyed_slot_store #(
  parameter int CAPACITY = kss_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kss_pkg::KEY_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  kss_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output kss_pkg::out_word_t  out_data
);
  import kss_pkg::*;

  sts_t  sts, sts_dp;
  ctl_t  ctl;
  in_word_t word_r;
  out_word_t res;

  always_ff @(posedge clk) begin
    if (ctl.load) word_r <= in_data;
  end

  always_comb begin
    sts_dp = sts;
  end

  kss_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_word(ctl.load ? in_data : word_r),
    .out_valid, .out_stall, .sts(sts_dp), .ctl
  );

  kss_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst_n, .in_word(ctl.load ? in_data : word_r), .ctl, .sts, .res
  );

  assign out_data = res;

`ifndef SYNTHESIS
  a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && ctl.link)) else $error("link into full table");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> in_stall) else $error("accepted during command");
  a_walk_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.res_walk |=> out_valid) else $error("walk word lost");
`endif

endmodule
`default_nettype wire
